// ----- design/apiwh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apiwh_pkg: shared types, constants and helper functions
// Widths, command and status codes, and the small constant tables used by
// the weighted ap history block.
// ----------------------------------------------------------------------------
package apiwh_pkg;

    localparam int HOUR_DEPTH = 65536;
    localparam int ADDR_W     = $clog2(HOUR_DEPTH);
    localparam int HC_W       = ADDR_W + 1;

    localparam int AP_W     = 10;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int BASE_W   = 22;
    localparam int RAP_W    = 23;
    localparam int STATUS_W = 2;

    // signed hour index and day arithmetic
    localparam int IDX_W = 29;
    localparam int DN_W  = 24;

    // weighted window: 34 taps ending one hour before the query
    localparam int TAPS    = 34;
    localparam int TAP_W   = 6;
    localparam int WGT_W   = 9;
    localparam int MIN_IDX = TAPS;

    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(2436205);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // floor(x / 3) for x < 8192: reciprocal multiply
    function automatic logic [AP_W-1:0] div3(input logic [AP_W+1:0] x);
        logic [25:0] p;
        begin
            p = 26'(x) * 26'(2731);
            return AP_W'(p >> 13);
        end
    endfunction

    // 367 * (m - 2 - 12a) / 12, with a = -1 for months 0..2
    function automatic logic [8:0] month_term(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        begin
            case (m)
                4'd0:    r = 9'd305;
                4'd1:    r = 9'd336;
                4'd2:    r = 9'd367;
                4'd3:    r = 9'd30;
                4'd4:    r = 9'd61;
                4'd5:    r = 9'd91;
                4'd6:    r = 9'd122;
                4'd7:    r = 9'd152;
                4'd8:    r = 9'd183;
                4'd9:    r = 9'd214;
                4'd10:   r = 9'd244;
                4'd11:   r = 9'd275;
                4'd12:   r = 9'd305;
                4'd13:   r = 9'd336;
                4'd14:   r = 9'd367;
                default: r = 9'd397;
            endcase
            return r;
        end
    endfunction

    // hour mod 3 == 2; powers of two alternate 1, 2 mod 3
    function automatic logic hour_mod3_is2(input logic [HOUR_W-1:0] h);
        logic [2:0] r;
        begin
            r = 3'(h[0]) + 3'(h[2]) + 3'(h[4]) + 3'({h[1], 1'b0}) + 3'({h[3], 1'b0});
            if (r >= 3'd6)
                r = r - 3'd6;
            else if (r >= 3'd3)
                r = r - 3'd3;
            return (r == 3'd2);
        end
    endfunction

    // weight x270 of tap j (address idx-34+j); the 189 term lands on
    // idx-2 or idx-1 depending on the hour phase
    function automatic logic [WGT_W-1:0] tap_weight(input logic [TAP_W-1:0] j,
                                                    input logic extra);
        logic [WGT_W-1:0] w;
        begin
            case (j)
                6'd26:   w = 9'd270;
                6'd27:   w = 9'd180;
                6'd28:   w = 9'd90;
                6'd29:   w = 9'd0;
                6'd30:   w = 9'd90;
                6'd31:   w = 9'd180;
                6'd32:   w = extra ? 9'd459 : 9'd270;
                6'd33:   w = extra ? 9'd0 : 9'd189;
                default: w = WGT_W'(10 * (int'(j) + 1));
            endcase
            return w;
        end
    endfunction

endpackage

// ----- design/apiwh_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apiwh_if: item and result channels
// Valid/ready channels carrying a command item and a result item.
// ----------------------------------------------------------------------------
interface apiwh_in_if import apiwh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [AP_W-1:0]    ap_value;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_of_month;
    logic [HOUR_W-1:0]  hour_of_day;

    modport source (output valid, cmd, ap_value, year, month, day_of_month,
                    hour_of_day, input ready);
    modport sink   (input valid, cmd, ap_value, year, month, day_of_month,
                    hour_of_day, output ready);
endinterface

interface apiwh_out_if import apiwh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [RAP_W-1:0]    rap_x270;
    logic [STATUS_W-1:0] status;

    modport source (output valid, rap_x270, status, input ready);
    modport sink   (input valid, rap_x270, status, output ready);
endinterface

// ----- design/apiwh_hour_index.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apiwh_hour_index: date to hour index
// Three-stage pipeline: Julian day number of the date, offset from the base
// day, times 24 plus the hour.
// ----------------------------------------------------------------------------
module apiwh_hour_index import apiwh_pkg::*;
(
    input  logic                     clk,
    input  logic [YEAR_W-1:0]        year,
    input  logic [MONTH_W-1:0]       month,
    input  logic [DAY_W-1:0]         day_of_month,
    input  logic [HOUR_W-1:0]        hour_of_day,
    input  logic [BASE_W-1:0]        base_day_number,
    output logic signed [IDX_W-1:0]  idx
);

    logic              early;     // months 0..2 borrow a year
    logic [13:0]       ya;
    logic [13:0]       yb;
    logic [24:0]       p1;
    logic [26:0]       p3;
    logic [8:0]        q3;
    logic [DN_W-1:0]   t1;
    logic [DN_W-1:0]   rest;

    logic [DN_W-1:0]   t1_reg;
    logic [DN_W-1:0]   rest_reg;
    logic [HOUR_W-1:0] h1_reg;
    logic [DN_W-1:0]   diff_reg;
    logic [HOUR_W-1:0] h2_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  diff_ext;

    always_comb
    begin
        early = (month <= 4'd2);
        ya    = 14'(year) + 14'(4800) - 14'(early);
        yb    = 14'(year) + 14'(4900) - 14'(early);
        p1    = 25'(ya) * 25'(1461);
        t1    = DN_W'(p1 >> 2);
        // floor(yb / 100) via reciprocal, then 3 * q / 4
        p3    = 27'(yb) * 27'(5243);
        q3    = 9'(p3[26:19]) * 9'(3);
        rest  = DN_W'(day_of_month) + DN_W'(month_term(month))
              - DN_W'(q3[8:2]) - DN_W'(32075);
    end

    assign diff_ext = {{(IDX_W-DN_W){diff_reg[DN_W-1]}}, diff_reg};

    always_ff @(posedge clk)
    begin
        t1_reg   <= t1;
        rest_reg <= rest;
        h1_reg   <= hour_of_day;
        diff_reg <= t1_reg + rest_reg - DN_W'(base_day_number);
        h2_reg   <= h1_reg;
        idx_reg  <= (diff_ext << 4) + (diff_ext << 3) + IDX_W'(h2_reg);
    end

    assign idx = $signed(idx_reg);

endmodule

// ----- design/ap_index_weighted_history.sv -----
`timescale 1ns / 1ps
// One transaction at a time; a query is paced by the 34 reads through
//   the single read port of the hourly store (none when outside the
//   history), a load by its writes.
// On reset, control, hour count and previous sample clear and the base day
//   returns to BASE_RESET at once; the hourly store is not cleared (entries
//   are read only after written).
// ----------------------------------------------------------------------------
// ap_index_weighted_history: hourly ap store with storm-weighted query
// Loads write a 3-hour sample plus two interpolated hours; queries turn a
// date into an hour index and accumulate the 34-tap weighted sum times 270.
// ----------------------------------------------------------------------------
module ap_index_weighted_history import apiwh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [BASE_W-1:0] cfg_wdata,
    apiwh_in_if.sink          item,
    apiwh_out_if.source       result
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_IDX   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [TAP_W-1:0] IDX_LAT  = TAP_W'(3);
    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAPS - 1);

    // control state
    logic [2:0]          state_reg, state_next;
    logic [TAP_W-1:0]    cnt_reg, cnt_next;
    logic [HC_W-1:0]     hc_reg, hc_next;
    logic [AP_W-1:0]     prev_reg, prev_next;
    logic [BASE_W-1:0]   base_reg;
    logic                rd_pend_reg, rd_pend_next;
    logic                out_valid_reg, out_valid_next;

    // payload
    logic                cmd_reg;
    logic [AP_W-1:0]     ap_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [DAY_W-1:0]    day_reg;
    logic [HOUR_W-1:0]   hour_reg;
    logic [ADDR_W-1:0]   rbase_reg, rbase_next;
    logic [TAP_W-1:0]    rd_j_reg, rd_j_next;
    logic [RAP_W-1:0]    acc_reg, acc_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [RAP_W-1:0]    out_rap_reg, out_rap_next;
    logic [STATUS_W-1:0] out_st_reg, out_st_next;

    // hourly store
    logic [AP_W-1:0]     store_mem [HOUR_DEPTH];
    logic [AP_W-1:0]     rd_q_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [AP_W-1:0]     mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;

    logic                accept;
    logic signed [IDX_W-1:0] idx;
    logic [IDX_W-1:0]    idx_u;
    logic                in_history;
    logic                extra;
    logic [AP_W+WGT_W-1:0] prod;

    assign accept      = item.valid && item.ready;
    assign item.ready  = (state_reg == S_IDLE);

    assign result.valid    = out_valid_reg;
    assign result.rap_x270 = out_rap_reg;
    assign result.status   = out_st_reg;

    apiwh_hour_index u_hour_index (
        .clk             (clk),
        .year            (year_reg),
        .month           (month_reg),
        .day_of_month    (day_reg),
        .hour_of_day     (hour_reg),
        .base_day_number (base_reg),
        .idx             (idx)
    );

    // query window must lie in written history: 34 <= idx <= hour_count - 2
    assign idx_u      = $unsigned(idx);
    assign in_history = !idx_u[IDX_W-1] && (idx_u >= IDX_W'(MIN_IDX))
                        && ((idx_u + IDX_W'(2)) <= IDX_W'(hc_reg));
    assign extra      = hour_mod3_is2(hour_reg);
    assign prod       = (AP_W+WGT_W)'(rd_q_reg) * (AP_W+WGT_W)'(tap_weight(rd_j_reg, extra));
    assign mem_raddr  = rbase_reg + ADDR_W'(cnt_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        hc_next        = hc_reg;
        prev_next      = prev_reg;
        rbase_next     = rbase_reg;
        rd_pend_next   = 1'b0;
        rd_j_next      = cnt_reg;
        acc_next       = acc_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_rap_next   = out_rap_reg;
        out_st_next    = out_st_reg;
        mem_we         = 1'b0;
        mem_waddr      = hc_reg[ADDR_W-1:0];
        mem_wdata      = ap_reg;

        // accumulate the tap whose read data arrived this cycle
        if (rd_pend_reg)
            acc_next = acc_reg + RAP_W'(prod);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    acc_next   = '0;
                    st_next    = ST_OK;
                    state_next = (item.cmd == CMD_LOAD) ? S_LOAD : S_IDX;
                end
            end
            S_LOAD:
            begin
                if (hc_reg >= HC_W'(HOUR_DEPTH))
                begin
                    st_next    = ST_FULL;
                    state_next = S_DONE;
                end
                else if (cnt_reg == '0 && hc_reg < HC_W'(3))
                begin
                    // first sample: no interpolation
                    cnt_next = TAP_W'(2);
                end
                else
                begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + TAP_W'(1);
                    case (cnt_reg)
                        6'd0:
                        begin
                            mem_waddr = ADDR_W'(hc_reg - HC_W'(2));
                            mem_wdata = div3((AP_W+2)'({prev_reg, 1'b0})
                                             + (AP_W+2)'(ap_reg));
                        end
                        6'd1:
                        begin
                            mem_waddr = ADDR_W'(hc_reg - HC_W'(1));
                            mem_wdata = div3((AP_W+2)'(prev_reg)
                                             + (AP_W+2)'({ap_reg, 1'b0}));
                        end
                        default:
                        begin
                            prev_next  = ap_reg;
                            hc_next    = hc_reg + HC_W'(3);
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_IDX:
            begin
                cnt_next = cnt_reg + TAP_W'(1);
                if (cnt_reg == IDX_LAT - TAP_W'(1))
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cnt_next = '0;
                if (in_history)
                begin
                    rbase_next = ADDR_W'(idx_u - IDX_W'(MIN_IDX));
                    state_next = S_READ;
                end
                else
                begin
                    st_next    = ST_RANGE;
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                rd_pend_next = 1'b1;
                cnt_next     = cnt_reg + TAP_W'(1);
                if (cnt_reg == LAST_TAP)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_rap_next   = (st_reg == ST_OK) ? acc_reg : '0;
                    out_st_next    = st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            hc_reg        <= '0;
            prev_reg      <= '0;
            base_reg      <= BASE_RESET;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            hc_reg        <= hc_next;
            prev_reg      <= prev_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                base_reg <= cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= item.cmd;
            ap_reg    <= item.ap_value;
            year_reg  <= item.year;
            month_reg <= item.month;
            day_reg   <= item.day_of_month;
            hour_reg  <= item.hour_of_day;
        end
        rbase_reg   <= rbase_next;
        rd_j_reg    <= rd_j_next;
        acc_reg     <= acc_next;
        st_reg      <= (cmd_reg == CMD_QUERY || cmd_reg == CMD_LOAD) ? st_next : ST_OK;
        out_rap_reg <= out_rap_next;
        out_st_reg  <= out_st_next;
    end

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        rd_q_reg <= store_mem[mem_raddr];
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the weighted ap history block
// Directed table first, then random load/query traffic over several base day
// settings with random idling on both channels and one long output stall,
// then a back-to-back run with no idling and queries at both history ends.
// Every result is checked field by field against the predictor or a typed row.
// ----------------------------------------------------------------------------
module tb_top;
    import apiwh_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int RST_CYCLES  = 6;
    localparam int HOLD_CYCLES = 400;   // long output stall to back up the block
    localparam int DRAIN_WAIT  = 60;    // longer than the query latency

    // one input transaction and one result transaction
    typedef struct packed {
        logic               cmd;
        logic [AP_W-1:0]    ap;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
    } ap_req_t;

    typedef struct packed {
        logic [RAP_W-1:0]    rap;
        logic [STATUS_W-1:0] status;
    } ap_resp_t;

    // directed row: when typed is set the result is written in by hand
    // (rap_x270 is then always zero and only the status is given)
    typedef struct packed {
        ap_req_t             req;
        logic                typed;
        logic [STATUS_W-1:0] want;
    } dir_row_t;

    localparam int REQ_W    = $bits(ap_req_t);
    localparam int DIR_ROWS = 24;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [BASE_W-1:0] cfg_wdata;

    apiwh_in_if  item_ch ();
    apiwh_out_if res_ch ();

    ap_index_weighted_history dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (res_ch)
    );

    // ------------------------------------------------------------------------
    // Predictor state: hourly history, hour count, last accepted sample and
    // the base day number as last written.
    // ------------------------------------------------------------------------
    logic [AP_W-1:0]   ap_hist [HOUR_DEPTH];
    int unsigned       hist_hours;
    logic [AP_W-1:0]   last_sample;
    logic [BASE_W-1:0] base_jdn;

    ap_resp_t pending_raps [$];     // expected results, oldest first
    int       mismatches;

    // idling controls, set by stimulus; holds_served counted by the output side
    bit tx_gaps;
    bit rx_stalls;
    int hold_requests;
    int holds_served;

    dir_row_t dir_rows [DIR_ROWS];

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Fliegel-Van Flandern day number, divisions truncate toward zero
    function automatic longint date_day_number(input longint y, input longint m,
                                               input longint d);
        longint a;
        a = (m - 14) / 12;
        return d - 32075 + 1461 * (y + 4800 + a) / 4
             + 367 * (m - 2 - a * 12) / 12
             - 3 * ((y + 4900 + a) / 100) / 4;
    endfunction

    function automatic longint hist_at(input longint i);
        if (i < 0 || i >= HOUR_DEPTH)
            return 0;
        return longint'(ap_hist[int'(i)]);
    endfunction

    // Applies one accepted transaction to the predictor state and returns
    // the result it must produce.
    function automatic ap_resp_t storm_rap_step(input ap_req_t t);
        ap_resp_t r;
        longint   idx;
        longint   acc;
        int       k;
        r.rap    = '0;
        r.status = ST_OK;
        if (t.cmd == CMD_LOAD) begin
            if (hist_hours >= HOUR_DEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                // the two hours between samples get truncating interpolation
                if (hist_hours >= 3) begin
                    ap_hist[hist_hours - 2] =
                        AP_W'((2 * int'(last_sample) + int'(t.ap)) / 3);
                    ap_hist[hist_hours - 1] =
                        AP_W'((int'(last_sample) + 2 * int'(t.ap)) / 3);
                end
                ap_hist[hist_hours] = t.ap;
                last_sample = t.ap;
                hist_hours += 3;
            end
        end
        else begin
            idx = 24 * (date_day_number(longint'(t.year), longint'(t.month),
                                        longint'(t.day)) - longint'(base_jdn))
                + longint'(t.hour);
            if (idx < MIN_IDX || idx > longint'(hist_hours) - 2) begin
                r.status = ST_RANGE;
            end
            else begin
                acc = 0;
                // linear weights 10..260 over the 26 oldest hours
                for (k = 1; k <= 26; k++)
                    acc += 10 * k * hist_at(idx - 35 + k);
                // ramp 270,180,90,0,90,180,270 over the next seven
                for (k = 0; k < 7; k++)
                    acc += 90 * ((k > 3) ? k - 3 : 3 - k) * hist_at(idx - 8 + k);
                // 0.7 of a recent hour, two back on the third hour of a slot
                acc += 189 * hist_at(idx - ((t.hour % 3 == 2) ? 2 : 1));
                r.rap = RAP_W'(acc);
            end
        end
        return r;
    endfunction

    // inverse of the day number, used only to aim queries at stored hours
    task automatic jdn_to_date(input longint jd, output longint y,
                               output longint m, output longint d);
        longint l;
        longint n;
        longint i;
        longint j;
        l = jd + 68569;
        n = 4 * l / 146097;
        l = l - (146097 * n + 3) / 4;
        i = 4000 * (l + 1) / 1461001;
        l = l - 1461 * i / 4 + 31;
        j = 80 * l / 2447;
        d = l - 2447 * j / 80;
        l = j / 11;
        m = j + 2 - 12 * l;
        y = 100 * (n - 49) + i + l;
    endtask

    // Builds a query landing on hour index target. At random the date is
    // written in an equivalent odd form: hour past 23, day 0, month 0/13/14.
    task automatic make_query(input longint target, output ap_req_t r);
        longint jd;
        longint h;
        longint y;
        longint m;
        longint d;
        r = REQ_W'({$urandom, $urandom});
        h = target % 24;
        jd = longint'(base_jdn) + target / 24;
        if (h >= 0 && h <= 7 && $urandom_range(0, 1)) begin
            jd = jd - 1;
            h = h + 24;
        end
        jdn_to_date(jd + 1, y, m, d);
        if (d == 1 && $urandom_range(0, 1))
            d = 0;
        else
            jdn_to_date(jd, y, m, d);
        if (m <= 2 && $urandom_range(0, 1)) begin
            m = m + 12;
            y = y - 1;
        end
        else if (m == 12 && $urandom_range(0, 1)) begin
            m = 0;
            y = y + 1;
        end
        r.cmd   = CMD_QUERY;
        r.year  = YEAR_W'(y);
        r.month = MONTH_W'(m);
        r.day   = DAY_W'(d);
        r.hour  = HOUR_W'(h);
    endtask

    function automatic dir_row_t load_row(input int v);
        dir_row_t row;
        row.req       = '0;
        row.req.cmd   = CMD_LOAD;
        row.req.ap    = AP_W'(v);
        row.typed     = 1'b1;
        row.want      = ST_OK;
        return row;
    endfunction

    function automatic dir_row_t query_row(input int y, input int m, input int d,
                                           input int h, input logic typed,
                                           input logic [STATUS_W-1:0] want);
        dir_row_t row;
        row.req       = '0;
        row.req.cmd   = CMD_QUERY;
        row.req.year  = YEAR_W'(y);
        row.req.month = MONTH_W'(m);
        row.req.day   = DAY_W'(d);
        row.req.hour  = HOUR_W'(h);
        row.typed     = typed;
        row.want      = want;
        return row;
    endfunction

    // random gap on the input side, when tx_gaps is set
    task automatic maybe_pause();
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Offers one transaction, holds it until accepted, then records the
    // expected result. valid is left high for a following transaction.
    task automatic offer(input ap_req_t r, input logic typed,
                         input logic [STATUS_W-1:0] want);
        ap_resp_t p;
        item_ch.valid        <= 1'b1;
        item_ch.cmd          <= r.cmd;
        item_ch.ap_value     <= r.ap;
        item_ch.year         <= r.year;
        item_ch.month        <= r.month;
        item_ch.day_of_month <= r.day;
        item_ch.hour_of_day  <= r.hour;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        p = storm_rap_step(r);
        if (typed) begin
            p.rap    = '0;
            p.status = want;
        end
        pending_raps.insert(pending_raps.size(), p);
    endtask

    // wait until every result is back
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending_raps.size() != 0)
            @(posedge clk);
    endtask

    // base day is written only with nothing in flight
    task automatic write_base(input logic [BASE_W-1:0] v);
        drain();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        base_jdn = v;
    endtask

    // Random traffic: loads, queries aimed inside the history, queries at
    // its edges, and fully random fields. Idling mode changes every 64.
    task automatic run_phase(input int n_items);
        ap_req_t    r;
        int         i;
        int         sel;
        logic [1:0] mode;
        longint     tgt;
        for (i = 0; i < n_items; i++) begin
            if (i % 64 == 0) begin
                mode      = 2'($urandom_range(0, 3));
                tx_gaps   = mode[0];
                rx_stalls = mode[1];
            end
            sel = $urandom_range(0, 99);
            r = REQ_W'({$urandom, $urandom});
            if (sel < 35) begin
                r.cmd = CMD_LOAD;
                if (sel < 3)
                    r.ap = '0;
                else if (sel < 6)
                    r.ap = '1;
            end
            else if (sel < 80 && hist_hours >= 36) begin
                make_query(longint'($urandom_range(MIN_IDX, hist_hours - 2)), r);
            end
            else if (sel < 90) begin
                case ($urandom_range(0, 3))
                    0:       tgt = MIN_IDX - 1;
                    1:       tgt = MIN_IDX;
                    2:       tgt = longint'(hist_hours) - 2;
                    default: tgt = longint'(hist_hours) - 1;
                endcase
                make_query(tgt, r);
            end
            else begin
                r.cmd = CMD_QUERY;
            end
            maybe_pause();
            offer(r, 1'b0, ST_OK);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random ready bursts, plus the long hold when requested.
    // ------------------------------------------------------------------------
    initial begin : result_ready
        res_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_requests != holds_served) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                holds_served++;
            end
            else if (rx_stalls && $urandom_range(0, 7) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(posedge clk);
            end
            else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each accepted result against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        ap_resp_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_raps.size() == 0) begin
                $error("unexpected result: rap_x270 %0d status %0d",
                       res_ch.rap_x270, res_ch.status);
                mismatches++;
            end
            else begin
                want = pending_raps.pop_front();
                if (res_ch.rap_x270 !== want.rap) begin
                    $error("rap_x270 mismatch: expected %0d, got %0d",
                           want.rap, res_ch.rap_x270);
                    mismatches++;
                end
                if (res_ch.status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, res_ch.status);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        ap_req_t r;
        int      i;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        item_ch.valid        = 1'b0;
        item_ch.cmd          = CMD_LOAD;
        item_ch.ap_value     = '0;
        item_ch.year         = '0;
        item_ch.month        = '0;
        item_ch.day_of_month = '0;
        item_ch.hour_of_day  = '0;
        mismatches           = 0;
        hold_requests        = 0;
        holds_served         = 0;
        tx_gaps              = 1'b1;
        rx_stalls            = 1'b1;
        hist_hours           = 0;
        last_sample          = '0;
        base_jdn             = BASE_RESET;
        for (i = 0; i < HOUR_DEPTH; i++)
            ap_hist[i] = '0;

        // Directed table. Base day after reset is 1958-01-01, so day 2 hour
        // 10 is hour index 34, the first one with a full window.
        dir_rows[0]  = query_row(1958, 1, 2, 10, 1'b1, ST_RANGE); // empty store
        dir_rows[1]  = load_row(0);                               // first sample
        dir_rows[2]  = load_row(1023);
        dir_rows[3]  = load_row(999);
        dir_rows[4]  = load_row(1);
        dir_rows[5]  = load_row(512);
        dir_rows[6]  = load_row(511);
        dir_rows[7]  = load_row(1023);
        dir_rows[8]  = load_row(0);
        dir_rows[9]  = load_row(300);
        dir_rows[10] = load_row(700);
        dir_rows[11] = load_row(42);
        dir_rows[12] = query_row(1958, 1, 2, 10, 1'b1, ST_RANGE); // 33 hours only
        dir_rows[13] = load_row(888);
        dir_rows[14] = load_row(5);                               // 39 hours
        dir_rows[15] = query_row(1958, 1, 2, 10, 1'b0, ST_OK);   // lowest index
        dir_rows[16] = query_row(1958, 1, 2, 13, 1'b0, ST_OK);   // newest allowed
        dir_rows[17] = query_row(1958, 1, 2, 11, 1'b0, ST_OK);   // third-hour phase
        dir_rows[18] = query_row(1957, 13, 2, 12, 1'b0, ST_OK);  // month 13 alias
        dir_rows[19] = query_row(1958, 1, 2, 14, 1'b1, ST_RANGE); // one past end
        dir_rows[20] = query_row(1958, 1, 2, 9, 1'b1, ST_RANGE);  // one too early
        dir_rows[21] = query_row(0, 0, 0, 0, 1'b1, ST_RANGE);     // all zero
        dir_rows[22] = query_row(4095, 15, 31, 31, 1'b1, ST_RANGE); // all ones
        dir_rows[23] = load_row(1023);

        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++) begin
            maybe_pause();
            offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        end

        // random phases across base day settings; long output stall first
        hold_requests++;
        run_phase(600);
        write_base(BASE_W'(2472729));
        run_phase(500);
        write_base(BASE_W'($urandom_range(2436205, 2472729)));
        run_phase(450);
        write_base('1);
        run_phase(40);
        write_base('0);
        run_phase(40);
        write_base(BASE_RESET);
        run_phase(150);

        // Last part, no idling: loads and queries back to back, then
        // queries at both ends of the history.
        drain();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        for (i = 0; i < 150; i++) begin
            r = REQ_W'({$urandom, $urandom});
            if (hist_hours < 36 || $urandom_range(0, 2) == 0)
                r.cmd = CMD_LOAD;
            else
                make_query(longint'($urandom_range(MIN_IDX, hist_hours - 2)), r);
            offer(r, 1'b0, ST_OK);
        end
        make_query(longint'(hist_hours) - 2, r);
        offer(r, 1'b0, ST_OK);
        make_query(longint'(hist_hours) - 1, r);
        offer(r, 1'b0, ST_OK);
        make_query(MIN_IDX, r);
        offer(r, 1'b0, ST_OK);

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hard stop, several times the slowest legal run
    initial begin : watchdog
        #(30_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/apiwh_pkg.sv
design/apiwh_if.sv
design/apiwh_hour_index.sv
design/ap_index_weighted_history.sv
bench/tb_top.sv
